// File: src/pas_pkg.sv
package pas_pkg;

  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ANG_W = ANGLE_FRAC_BITS + 2;
  localparam int THR_W = 15;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(819);

  localparam int COORD_W = 32;
  localparam int MAG_W = COORD_W + 1;
  localparam int CRD_FRAC = 24;
  localparam int CRD_ITERS = 24;
  localparam int IT_W = $clog2(CRD_ITERS);
  localparam int XW = MAG_W + CRD_FRAC + 3;
  localparam int ZW = 28;
  localparam logic signed [ZW-1:0] HALF_PI = ZW'(26353589);
  localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(1) <<< (CRD_FRAC - 1 - ANGLE_FRAC_BITS);

  typedef struct packed {
    logic             done;
    logic             ok;
    logic [ANG_W-1:0] angle;
  } pas_crd_rsp_t;

  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      eol;
  } pas_emit_t;

  function automatic logic signed [ZW-1:0] crd_atan(input logic [IT_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      IT_W'(0): v = ZW'(13176795);
      IT_W'(1): v = ZW'(7778716);
      IT_W'(2): v = ZW'(4110060);
      IT_W'(3): v = ZW'(2086331);
      IT_W'(4): v = ZW'(1047214);
      IT_W'(5): v = ZW'(524117);
      IT_W'(6): v = ZW'(262123);
      IT_W'(7): v = ZW'(131069);
      IT_W'(8): v = ZW'(65536);
      default:  v = ZW'(1) << (IT_W'(CRD_FRAC) - i);
    endcase
    return v;
  endfunction

endpackage

// File: src/pas_cordic.sv
module pas_cordic
  import pas_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [COORD_W-1:0] px,
  input  logic signed [COORD_W-1:0] py,
  input  logic signed [COORD_W-1:0] ax,
  input  logic signed [COORD_W-1:0] ay,
  output pas_crd_rsp_t              rsp
);

  localparam logic [2:0] C_IDLE  = 3'd0;
  localparam logic [2:0] C_INIT  = 3'd1;
  localparam logic [2:0] C_ITER  = 3'd2;
  localparam logic [2:0] C_ROUND = 3'd3;

  logic [2:0] state_r, state_nxt;
  logic signed [MAG_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [XW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [IT_W-1:0] it_r, it_nxt;
  logic base_r, base_nxt;
  logic zero_r, zero_nxt;
  logic done_r, done_nxt;
  logic [ANG_W-1:0] ang_r, ang_nxt;

  logic [MAG_W-1:0] adx, mx, my;
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] zb, zc, zsum;

  always_comb begin
    adx = dx_r[MAG_W-1] ? MAG_W'(-dx_r) : MAG_W'(dx_r);
    mx = dy_r[MAG_W-1] ? adx : MAG_W'(dy_r);
    my = dy_r[MAG_W-1] ? MAG_W'(-dy_r) : adx;
    xs = x_r >>> it_r;
    ys = y_r >>> it_r;
    zb = z_r + (base_r ? HALF_PI : ZW'(0));
    zc = zb[ZW-1] ? ZW'(0) : zb;
    zsum = zc + ROUND_HALF;
  end

  always_comb begin
    state_nxt = state_r;
    dx_nxt = dx_r;
    dy_nxt = dy_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    it_nxt = it_r;
    base_nxt = base_r;
    zero_nxt = zero_r;
    done_nxt = 1'b0;
    ang_nxt = ang_r;
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          dx_nxt = MAG_W'(px) - MAG_W'(ax);
          dy_nxt = MAG_W'(py) - MAG_W'(ay);
          state_nxt = C_INIT;
        end
      end
      C_INIT: begin
        x_nxt = {3'b000, mx, {CRD_FRAC{1'b0}}};
        y_nxt = {3'b000, my, {CRD_FRAC{1'b0}}};
        z_nxt = '0;
        it_nxt = '0;
        base_nxt = dy_r[MAG_W-1];
        zero_nxt = (dx_r == '0) && (dy_r == '0);
        state_nxt = C_ITER;
      end
      C_ITER: begin
        if (!y_r[XW-1]) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + crd_atan(it_r);
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - crd_atan(it_r);
        end
        it_nxt = it_r + IT_W'(1);
        if (it_r == IT_W'(CRD_ITERS - 1)) begin
          state_nxt = C_ROUND;
        end
      end
      C_ROUND: begin
        ang_nxt = zsum[CRD_FRAC-ANGLE_FRAC_BITS +: ANG_W];
        done_nxt = 1'b1;
        state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r <= done_nxt;
    end
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    it_r <= it_nxt;
    base_r <= base_nxt;
    zero_r <= zero_nxt;
    ang_r <= ang_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.ok = !zero_r;
  assign rsp.angle = zero_r ? '0 : ang_r;

endmodule

// File: src/pas_ctrl.sv
module pas_ctrl
  import pas_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  input  logic                      in_final_point,
  input  logic [THR_W-1:0]          thr,
  output pas_emit_t                 emit,
  input  logic                      emit_ready,
  output logic                      crd_start,
  output logic signed [COORD_W-1:0] crd_px,
  output logic signed [COORD_W-1:0] crd_py,
  output logic signed [COORD_W-1:0] crd_ax,
  output logic signed [COORD_W-1:0] crd_ay,
  input  pas_crd_rsp_t              crd_rsp
);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_EMIT_FIRST = 3'd1;
  localparam logic [2:0] S_START1     = 3'd2;
  localparam logic [2:0] S_WAIT1      = 3'd3;
  localparam logic [2:0] S_EMIT_HELD  = 3'd4;
  localparam logic [2:0] S_START2     = 3'd5;
  localparam logic [2:0] S_WAIT2      = 3'd6;
  localparam logic [2:0] S_FIN        = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] seen_r, seen_nxt;
  logic signed [COORD_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic fin_r, fin_nxt;
  logic signed [COORD_W-1:0] anc_x_r, anc_x_nxt, anc_y_r, anc_y_nxt;
  logic signed [COORD_W-1:0] held_x_r, held_x_nxt, held_y_r, held_y_nxt;
  logic [ANG_W-1:0] held_ang_r, held_ang_nxt;
  logic held_inv_r, held_inv_nxt;

  logic [ANG_W-1:0] diff;
  logic drop;

  always_comb begin
    diff = (crd_rsp.angle >= held_ang_r) ? crd_rsp.angle - held_ang_r
                                         : held_ang_r - crd_rsp.angle;
    drop = crd_rsp.ok && !held_inv_r && (32'(diff) < 32'(thr));
  end

  assign in_stall = (state_r != S_IDLE);
  assign crd_start = (state_r == S_START1) || (state_r == S_START2);
  assign crd_px = px_r;
  assign crd_py = py_r;
  assign crd_ax = anc_x_r;
  assign crd_ay = anc_y_r;

  always_comb begin
    emit.valid = 1'b0;
    emit.x = px_r;
    emit.y = py_r;
    emit.eol = 1'b1;
    unique case (state_r)
      S_EMIT_FIRST: begin
        emit.valid = 1'b1;
        emit.eol = fin_r;
      end
      S_EMIT_HELD: begin
        emit.valid = 1'b1;
        emit.x = held_x_r;
        emit.y = held_y_r;
        emit.eol = 1'b0;
      end
      S_FIN: emit.valid = fin_r;
      default: emit.valid = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    seen_nxt = seen_r;
    px_nxt = px_r;
    py_nxt = py_r;
    fin_nxt = fin_r;
    anc_x_nxt = anc_x_r;
    anc_y_nxt = anc_y_r;
    held_x_nxt = held_x_r;
    held_y_nxt = held_y_r;
    held_ang_nxt = held_ang_r;
    held_inv_nxt = held_inv_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          px_nxt = in_pos_x;
          py_nxt = in_pos_y;
          fin_nxt = in_final_point;
          state_nxt = (seen_r == 2'd0) ? S_EMIT_FIRST : S_START1;
        end
      end
      S_EMIT_FIRST: begin
        if (emit_ready) begin
          anc_x_nxt = px_r;
          anc_y_nxt = py_r;
          seen_nxt = fin_r ? 2'd0 : 2'd1;
          state_nxt = S_IDLE;
        end
      end
      S_START1: state_nxt = S_WAIT1;
      S_WAIT1: begin
        if (crd_rsp.done) begin
          if (seen_r == 2'd1) begin
            held_x_nxt = px_r;
            held_y_nxt = py_r;
            held_ang_nxt = crd_rsp.angle;
            held_inv_nxt = !crd_rsp.ok;
            state_nxt = S_FIN;
          end else if (drop) begin
            held_x_nxt = px_r;
            held_y_nxt = py_r;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_EMIT_HELD;
          end
        end
      end
      S_EMIT_HELD: begin
        if (emit_ready) begin
          anc_x_nxt = held_x_r;
          anc_y_nxt = held_y_r;
          state_nxt = S_START2;
        end
      end
      S_START2: state_nxt = S_WAIT2;
      S_WAIT2: begin
        if (crd_rsp.done) begin
          held_x_nxt = px_r;
          held_y_nxt = py_r;
          held_ang_nxt = crd_rsp.angle;
          held_inv_nxt = !crd_rsp.ok;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!fin_r) begin
          seen_nxt = 2'd2;
          state_nxt = S_IDLE;
        end else if (emit_ready) begin
          seen_nxt = 2'd0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seen_r <= 2'd0;
      anc_x_r <= '0;
      anc_y_r <= '0;
      held_x_r <= '0;
      held_y_r <= '0;
      held_ang_r <= '0;
      held_inv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seen_r <= seen_nxt;
      anc_x_r <= anc_x_nxt;
      anc_y_r <= anc_y_nxt;
      held_x_r <= held_x_nxt;
      held_y_r <= held_y_nxt;
      held_ang_r <= held_ang_nxt;
      held_inv_r <= held_inv_nxt;
    end
    px_r <= px_nxt;
    py_r <= py_nxt;
    fin_r <= fin_nxt;
  end

endmodule

// File: src/polyline_angle_simplifier_top.sv
// Angle-threshold polyline simplifier.
// Input requests (in_valid / in_stall) carry one point each: in_pos_x, in_pos_y and
// in_final_point on the last point of a polyline. Result requests (out_valid /
// out_stall) carry kept points; out_end_of_line marks the last kept point.
// A point whose direction from the last kept point differs from that of the pending
// point by less than the threshold replaces the pending point; otherwise the pending
// point is released. First and last points of a polyline are always released.
// The threshold (radians x 8192) is written through cfg_valid / cfg_ready /
// cfg_angle_threshold; the user must write it only while no point is in flight,
// which the block does not enforce. cfg_ready is always high. in_stall is high
// while one point is worked on. Every point after the first runs one 24-step
// CORDIC angle evaluation on the shared iterative unit, and a second one when the
// pending point is released. A single output register holds a result; while it
// holds one and out_stall is high the sequencer waits before releasing another
// result, and nothing is lost.
// Reset (rst_n, synchronous, active low) restores the threshold to 819, clears the
// anchor and pending point and starts a new polyline.
module polyline_angle_simplifier_top
  import pas_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  input  logic                      in_final_point,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_kept_x,
  output logic signed [COORD_W-1:0] out_kept_y,
  output logic                      out_end_of_line,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [THR_W-1:0]          cfg_angle_threshold
);

  logic [THR_W-1:0] thr_r;
  logic out_valid_r;
  logic signed [COORD_W-1:0] kept_x_r, kept_y_r;
  logic eol_r;

  pas_emit_t emit;
  logic emit_ready;
  logic crd_start;
  logic signed [COORD_W-1:0] crd_px, crd_py, crd_ax, crd_ay;
  pas_crd_rsp_t crd_rsp;

  assign cfg_ready = 1'b1;
  assign emit_ready = !out_valid_r || !out_stall;

  pas_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_final_point (in_final_point),
    .thr            (thr_r),
    .emit           (emit),
    .emit_ready     (emit_ready),
    .crd_start      (crd_start),
    .crd_px         (crd_px),
    .crd_py         (crd_py),
    .crd_ax         (crd_ax),
    .crd_ay         (crd_ay),
    .crd_rsp        (crd_rsp)
  );

  pas_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (crd_start),
    .px    (crd_px),
    .py    (crd_py),
    .ax    (crd_ax),
    .ay    (crd_ay),
    .rsp   (crd_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        thr_r <= cfg_angle_threshold;
      end
      if (emit.valid && emit_ready) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (emit.valid && emit_ready) begin
      kept_x_r <= emit.x;
      kept_y_r <= emit.y;
      eol_r <= emit.eol;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kept_x = kept_x_r;
  assign out_kept_y = kept_y_r;
  assign out_end_of_line = eol_r;

endmodule
